// ===== rtl/lob_pkg.sv =====
// Shared types and constants for the limit order book.
package lob_pkg;

  localparam int unsigned MAX_ORDERS_DEF   = 1024;
  localparam int unsigned PRICE_LEVELS_DEF = 256;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUP       = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  ord_id;
    logic        side;
    logic [7:0]  price_ticks;
    logic [31:0] quantity;
  } lob_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        bid_present;
    logic [7:0]  best_bid;
    logic        ask_present;
    logic [7:0]  best_ask;
    logic [10:0] live_orders;
  } lob_out_t;

endpackage

// ===== rtl/limit_order_book.sv =====
// Limit order book top level: order table, level table and best-price tracking.
// Each accepted item runs through the state machine to the result strobe; a modify
// does a cancel and then an add, and emptying the best level starts a rescan that
// reads one level at a time from the best end. The receiver cannot stall.
// Items are taken one at a time; busy falls with the strobe, so the next item
// can be taken in that cycle. Reset (rst_n low, synchronous) clears best prices
// and the live count, then runs a clearing pass over both memories with busy high.
module limit_order_book
  import lob_pkg::*;
#(
  parameter int unsigned MAX_ORDERS   = MAX_ORDERS_DEF,
  parameter int unsigned PRICE_LEVELS = PRICE_LEVELS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lob_in_t  in_item,
  output logic     out_valid,
  output lob_out_t out_item
);

  localparam int unsigned IW    = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int unsigned PW    = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
  localparam int unsigned LW    = PW + 1;
  localparam int unsigned NL    = 2 * PRICE_LEVELS;
  localparam int unsigned CW    = IW + 1;
  localparam int unsigned CLR_N = (MAX_ORDERS > NL) ? MAX_ORDERS : NL;
  localparam int unsigned CLRW  = $clog2(CLR_N);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RDE    = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_ULVL   = 4'd4;
  localparam logic [3:0] S_UFIXP  = 4'd5;
  localparam logic [3:0] S_UFIXN  = 4'd6;
  localparam logic [3:0] S_SCRD   = 4'd7;
  localparam logic [3:0] S_SCCK   = 4'd8;
  localparam logic [3:0] S_ALVL   = 4'd9;
  localparam logic [3:0] S_ALINK  = 4'd10;
  localparam logic [3:0] S_ALINK2 = 4'd11;
  localparam logic [3:0] S_AENT   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  // Order entry: live, side, price, quantity, prev, next.
  typedef struct packed {
    logic          live;
    logic          side;
    logic [PW-1:0] price;
    logic [31:0]   qty;
    logic [IW-1:0] prev;
    logic [IW-1:0] next;
  } ent_t;

  typedef struct packed {
    logic [IW-1:0] head;
    logic [IW-1:0] tail;
    logic [CW-1:0] cnt;
  } lvl_t;

  ent_t ent_mem [MAX_ORDERS];
  lvl_t lvl_mem [NL];

  logic [3:0]      state_r;
  logic [CLRW-1:0] clr_r;
  lob_in_t         req_r;
  logic [1:0]      status_r;
  logic            bidv_r, askv_r;
  logic [PW-1:0]   bid_r, ask_r;
  logic [CW-1:0]   rest_r;
  ent_t            ent_r;     // entry under work
  logic [LW-1:0]   lidx_r;
  logic [PW-1:0]   scan_r;
  logic            scan_side_r;
  logic [IW-1:0]   fix_a_r;
  logic [2:0]      fix_kind_r; // bit0 next of prev, bit1 prev of next, bit2 next of old tail
  logic            emptied_r;

  // Entry memory port
  logic          e_we, e_re;
  logic [IW-1:0] e_wa, e_ra;
  ent_t          e_wd, e_rd;
  // Level memory port
  logic          l_we, l_re;
  logic [LW-1:0] l_wa, l_ra;
  lvl_t          l_wd, l_rd;

  always_ff @(posedge clk) begin
    if (e_we) ent_mem[e_wa] <= e_wd;
    if (e_re) e_rd <= ent_mem[e_ra];
  end
  always_ff @(posedge clk) begin
    if (l_we) lvl_mem[l_wa] <= l_wd;
    if (l_re) l_rd <= lvl_mem[l_ra];
  end

  logic id_ok, px_ok;
  assign id_ok = (32'(req_r.ord_id) < MAX_ORDERS);
  assign px_ok = (32'(req_r.price_ticks) < PRICE_LEVELS);
  logic [IW-1:0] rid;
  logic [PW-1:0] rpx;
  assign rid = IW'(req_r.ord_id);
  assign rpx = PW'(req_r.price_ticks);

  function automatic logic [LW-1:0] lvl_of(input logic sd, input logic [PW-1:0] px);
    lvl_of = sd ? (LW'(PRICE_LEVELS) + {1'b0, px}) : {1'b0, px};
  endfunction

  logic [LW-1:0] scan_idx;
  assign scan_idx = lvl_of(scan_side_r, scan_r);

  always_comb begin
    e_we = 1'b0; e_re = 1'b0; e_wa = rid; e_ra = rid; e_wd = ent_r;
    l_we = 1'b0; l_re = 1'b0; l_wa = lidx_r; l_ra = lidx_r; l_wd = '0;
    unique case (state_r)
      S_CLR: begin
        e_we = (32'(clr_r) < MAX_ORDERS); e_wa = IW'(clr_r); e_wd = '0;
        l_we = (32'(clr_r) < NL); l_wa = LW'(clr_r);
      end
      S_RDE: e_re = 1'b1;
      S_CHK: begin
        l_re = 1'b1;
        l_ra = (req_r.mode == MODE_ADD) ? lvl_of(req_r.side, rpx)
                                        : lvl_of(e_rd.side, e_rd.price);
      end
      S_ULVL: begin
        // retire the entry; fetch its predecessor for relinking
        e_we = 1'b1; e_wd = ent_r; e_wd.live = 1'b0;
        e_re = (l_rd.cnt > CW'(1)) && (l_rd.head != rid);
        e_ra = ent_r.prev;
        l_we = 1'b1;
        l_wd = l_rd;
        if (l_rd.cnt > CW'(1)) begin
          if (l_rd.head == rid) l_wd.head = ent_r.next;
          if (l_rd.tail == rid) l_wd.tail = ent_r.prev;
        end
        if (l_rd.cnt != '0) l_wd.cnt = l_rd.cnt - CW'(1);
      end
      S_UFIXP: begin
        if (fix_kind_r[0]) begin
          e_we = 1'b1; e_wa = ent_r.prev; e_wd = e_rd; e_wd.next = ent_r.next;
        end
        e_re = fix_kind_r[1];
        e_ra = ent_r.next;
      end
      S_UFIXN: begin
        if (fix_kind_r[1]) begin
          e_we = 1'b1; e_wa = ent_r.next; e_wd = e_rd; e_wd.prev = ent_r.prev;
        end
      end
      S_SCRD: begin
        l_re = 1'b1; l_ra = scan_idx;
      end
      S_ALVL: l_re = 1'b1;
      S_ALINK: begin
        l_we = 1'b1;
        l_wd.cnt  = l_rd.cnt + CW'(1);
        l_wd.tail = rid;
        l_wd.head = (l_rd.cnt == '0) ? rid : l_rd.head;
        e_ra = l_rd.tail; e_re = (l_rd.cnt != '0);
      end
      S_ALINK2: begin
        if (fix_kind_r[2]) begin
          e_we = 1'b1; e_wa = fix_a_r; e_wd = e_rd; e_wd.next = rid;
        end
      end
      S_AENT: e_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      bidv_r     <= 1'b0; askv_r <= 1'b0;
      bid_r      <= '0;   ask_r  <= '0;
      rest_r     <= '0;
      out_valid  <= 1'b0;
      fix_kind_r <= '0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + CLRW'(1);
          if (clr_r == CLRW'(CLR_N - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          req_r <= in_item;
          state_r <= S_RDE;
        end
        S_RDE: state_r <= S_CHK;
        S_CHK: begin
          ent_r <= e_rd;
          status_r <= ST_OK;
          lidx_r <= (req_r.mode == MODE_ADD) ? lvl_of(req_r.side, rpx)
                                             : lvl_of(e_rd.side, e_rd.price);
          if (req_r.mode != MODE_ADD && req_r.mode != MODE_CANCEL
              && req_r.mode != MODE_MODIFY) begin
            state_r <= S_DONE;
          end else if (!id_ok) begin
            status_r <= ST_NOT_FOUND; state_r <= S_DONE;
          end else if (req_r.mode == MODE_ADD) begin
            if (!px_ok) begin
              status_r <= ST_NOT_FOUND; state_r <= S_DONE;
            end else if (e_rd.live) begin
              status_r <= ST_DUP; state_r <= S_DONE;
            end else begin
              state_r <= S_ALINK;
            end
          end else if (!e_rd.live || (req_r.mode == MODE_MODIFY && !px_ok)) begin
            status_r <= ST_NOT_FOUND; state_r <= S_DONE;
          end else begin
            state_r <= S_ULVL;
          end
        end
        S_ULVL: begin
          fix_kind_r <= {1'b0,
                         (l_rd.cnt > CW'(1)) && (l_rd.tail != rid),
                         (l_rd.cnt > CW'(1)) && (l_rd.head != rid)};
          emptied_r <= (l_rd.cnt <= CW'(1));
          if (rest_r != '0) rest_r <= rest_r - CW'(1);
          state_r <= S_UFIXP;
        end
        S_UFIXP: state_r <= S_UFIXN;
        S_UFIXN: begin
          lidx_r <= lvl_of(req_r.side, rpx);
          if (emptied_r && !ent_r.side && bidv_r && bid_r == ent_r.price) begin
            bidv_r <= 1'b0; bid_r <= '0;
            scan_side_r <= 1'b0; scan_r <= PW'(PRICE_LEVELS - 1); state_r <= S_SCRD;
          end else if (emptied_r && ent_r.side && askv_r && ask_r == ent_r.price) begin
            askv_r <= 1'b0; ask_r <= '0;
            scan_side_r <= 1'b1; scan_r <= '0; state_r <= S_SCRD;
          end else if (req_r.mode == MODE_MODIFY) begin
            state_r <= S_ALVL;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SCRD: state_r <= S_SCCK;
        S_SCCK: begin
          // walk one level per read from the best end
          if (l_rd.cnt != '0) begin
            if (scan_side_r) begin askv_r <= 1'b1; ask_r <= scan_r; end
            else begin bidv_r <= 1'b1; bid_r <= scan_r; end
            state_r <= (req_r.mode == MODE_MODIFY) ? S_ALVL : S_DONE;
          end else if (scan_side_r ? (scan_r == PW'(PRICE_LEVELS - 1)) : (scan_r == '0)) begin
            state_r <= (req_r.mode == MODE_MODIFY) ? S_ALVL : S_DONE;
          end else begin
            scan_r <= scan_side_r ? scan_r + PW'(1) : scan_r - PW'(1);
            state_r <= S_SCRD;
          end
        end
        S_ALVL: state_r <= S_ALINK;
        S_ALINK: begin
          fix_kind_r <= {l_rd.cnt != '0, 2'b00};
          fix_a_r <= l_rd.tail;
          ent_r.live  <= 1'b1;
          ent_r.side  <= req_r.side;
          ent_r.price <= rpx;
          ent_r.qty   <= req_r.quantity;
          ent_r.next  <= '0;
          ent_r.prev  <= (l_rd.cnt == '0) ? '0 : l_rd.tail;
          rest_r <= rest_r + CW'(1);
          if (!req_r.side) begin
            if (!bidv_r || rpx > bid_r) begin bidv_r <= 1'b1; bid_r <= rpx; end
          end else begin
            if (!askv_r || rpx < ask_r) begin askv_r <= 1'b1; ask_r <= rpx; end
          end
          state_r <= S_ALINK2;
        end
        S_ALINK2: state_r <= S_AENT;
        S_AENT: begin
          fix_kind_r <= '0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          state_r <= S_IDLE;
          out_valid <= 1'b1;
          out_item.status <= status_r;
          out_item.bid_present <= bidv_r;
          out_item.best_bid <= bidv_r ? 8'(bid_r) : 8'd0;
          out_item.ask_present <= askv_r;
          out_item.best_ask <= askv_r ? 8'(ask_r) : 8'd0;
          out_item.live_orders <= 11'(rest_r);
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  a_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.bid_present) |-> (out_item.best_bid == 8'd0))
    else $error("bid price without bid");
  a_ask_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.ask_present) |-> (out_item.best_ask == 8'd0))
    else $error("ask price without ask");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not start work");

endmodule

// ===== sim/tb.sv =====
// Testbench for the limit order book: random order flow checked against a behavioral book.
`timescale 1ns / 1ps

module tb;
  import lob_pkg::*;

  localparam int NUM_IDS   = 1024;
  localparam int NUM_PX    = 256;
  localparam int RAND_ITEMS = 700;

  class book_scoreboard;
    bit          live [NUM_IDS];
    bit          o_side [NUM_IDS];
    logic [7:0]  o_px [NUM_IDS];
    int unsigned lvl_cnt [2*NUM_PX];
    bit          bid_ok, ask_ok;
    logic [7:0]  bid_px, ask_px;
    int unsigned resting;
    lob_out_t    pending_q [$];
    int          errors;

    function void drop_order(int id);
      int l;
      l = o_side[id] * NUM_PX + o_px[id];
      if (lvl_cnt[l] > 0) lvl_cnt[l]--;
      live[id] = 0;
      if (resting > 0) resting--;
      if (lvl_cnt[l] == 0) begin
        if (o_side[id] == 0 && bid_ok && bid_px == o_px[id]) begin
          bid_ok = 0;
          bid_px = 0;
          for (int p = NUM_PX - 1; p >= 0; p--)
            if (lvl_cnt[p] != 0) begin
              bid_ok = 1;
              bid_px = 8'(p);
              break;
            end
        end
        if (o_side[id] == 1 && ask_ok && ask_px == o_px[id]) begin
          ask_ok = 0;
          ask_px = 0;
          for (int p = 0; p < NUM_PX; p++)
            if (lvl_cnt[NUM_PX + p] != 0) begin
              ask_ok = 1;
              ask_px = 8'(p);
              break;
            end
        end
      end
    endfunction

    function void rest_order(int id, bit sd, logic [7:0] px);
      live[id] = 1;
      o_side[id] = sd;
      o_px[id] = px;
      lvl_cnt[sd * NUM_PX + px]++;
      resting++;
      if (sd == 0) begin
        if (!bid_ok || px > bid_px) begin
          bid_ok = 1;
          bid_px = px;
        end
      end else if (!ask_ok || px < ask_px) begin
        ask_ok = 1;
        ask_px = px;
      end
    endfunction

    function void note_item(lob_in_t it);
      lob_out_t r;
      r.status = ST_OK;
      case (it.mode)
        MODE_ADD: begin
          if (live[it.ord_id]) r.status = ST_DUP;
          else rest_order(it.ord_id, it.side, it.price_ticks);
        end
        MODE_CANCEL: begin
          if (!live[it.ord_id]) r.status = ST_NOT_FOUND;
          else drop_order(it.ord_id);
        end
        MODE_MODIFY: begin
          if (!live[it.ord_id]) r.status = ST_NOT_FOUND;
          else begin
            drop_order(it.ord_id);
            rest_order(it.ord_id, it.side, it.price_ticks);
          end
        end
        default: ;
      endcase
      r.bid_present = bid_ok;
      r.best_bid    = bid_ok ? bid_px : 8'd0;
      r.ask_present = ask_ok;
      r.best_ask    = ask_ok ? ask_px : 8'd0;
      r.live_orders = resting[10:0];
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(lob_out_t got);
      lob_out_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.bid_present !== e.bid_present) begin
        $error("bid_present exp %0d got %0d", e.bid_present, got.bid_present); errors++;
      end
      if (got.best_bid !== e.best_bid) begin
        $error("best_bid exp %0d got %0d", e.best_bid, got.best_bid); errors++;
      end
      if (got.ask_present !== e.ask_present) begin
        $error("ask_present exp %0d got %0d", e.ask_present, got.ask_present); errors++;
      end
      if (got.best_ask !== e.best_ask) begin
        $error("best_ask exp %0d got %0d", e.best_ask, got.best_ask); errors++;
      end
      if (got.live_orders !== e.live_orders) begin
        $error("live_orders exp %0d got %0d", e.live_orders, got.live_orders); errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  lob_in_t  in_item;
  logic     out_valid;
  lob_out_t out_item;

  book_scoreboard book;
  int live_ids [$];

  limit_order_book dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) book.check_result(out_item);
  end

  function automatic int gap_len();
    int n;
    n = $urandom_range(0, 99);
    if (n < 40) n = 0;
    else if (n < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    return n;
  endfunction

  // Hold start until the item is taken; drop it only when a gap follows.
  task automatic send_item(logic [1:0] md, int id, int sd, int px, int unsigned qty);
    lob_in_t it;
    int n;
    it.mode = md;
    it.ord_id = 10'(id);
    it.side = sd[0];
    it.price_ticks = 8'(px);
    it.quantity = qty;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    book.note_item(it);
    n = gap_len();
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_live();
    live_ids.delete();
    for (int i = 0; i < NUM_IDS; i++)
      if (book.live[i]) live_ids.insert(live_ids.size(), i);
    if (live_ids.size() == 0) return $urandom_range(0, NUM_IDS - 1);
    return live_ids[$urandom_range(0, live_ids.size() - 1)];
  endfunction

  initial begin
    int r, id, waited;
    book = new();
    rst_n = 0;
    start = 0;
    in_item = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, each mode, duplicates, misses, best-level rescans
    send_item(MODE_CANCEL, 0, 0, 0, 0);
    send_item(MODE_MODIFY, 1023, 1, 255, 32'hFFFF_FFFF);
    send_item(MODE_ADD, 0, 0, 0, 0);
    send_item(MODE_ADD, 1023, 1, 255, 32'hFFFF_FFFF);
    send_item(MODE_ADD, 0, 1, 10, 5);
    send_item(MODE_ADD, 5, 0, 255, 32'h5555_5555);
    send_item(MODE_ADD, 6, 0, 255, 32'hAAAA_AAAA);
    send_item(MODE_ADD, 7, 1, 0, 1);
    send_item(MODE_ADD, 8, 1, 0, 2);
    send_item(MODE_CANCEL, 5, 1, 3, 0);
    send_item(MODE_CANCEL, 6, 0, 0, 0);
    send_item(MODE_MODIFY, 7, 0, 128, 9);
    send_item(MODE_CANCEL, 8, 0, 0, 0);
    send_item(2'd3, 9, 1, 200, 7);
    send_item(MODE_MODIFY, 0, 1, 255, 0);
    send_item(MODE_CANCEL, 1023, 0, 0, 0);
    send_item(MODE_CANCEL, 1023, 0, 0, 0);
    send_item(MODE_CANCEL, 0, 0, 0, 0);
    send_item(MODE_CANCEL, 7, 0, 0, 0);

    // random: mostly ops on live ids, narrow price band to share levels
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        id = (r < 5) ? pick_live() : $urandom_range(0, 63) + ($urandom_range(0, 1) ? 960 : 0);
        send_item(MODE_ADD, id, $urandom_range(0, 1),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(120, 135),
                  $urandom());
      end else if (r < 70) begin
        send_item(MODE_CANCEL, (r < 67) ? pick_live() : $urandom_range(0, 1023),
                  $urandom_range(0, 1), $urandom_range(0, 255), $urandom());
      end else if (r < 97) begin
        send_item(MODE_MODIFY, (r < 94) ? pick_live() : $urandom_range(0, 1023),
                  $urandom_range(0, 1), $urandom_range(118, 137), $urandom());
      end else begin
        send_item(2'd3, $urandom_range(0, 1023), $urandom_range(0, 1),
                  $urandom_range(0, 255), $urandom());
      end
    end
    start <= 1'b0;

    waited = 0;
    while (book.pending_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (book.pending_q.size() == 0 && book.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
